// File: rtl/core/dmpb_pkg.sv
// ----------------------------------------------------------------------------
// dmpb_pkg
// Shared types and constants for the digest modulo partitioner / batcher.
// ----------------------------------------------------------------------------
package dmpb_pkg;

  // key geometry
  localparam int KEY_W       = 160;
  localparam int NIB_W       = 4;
  localparam int KEY_NIBBLES = 40;
  localparam int NIBCNT_W    = 6;

  // field widths
  localparam int PART_W = 6;
  localparam int CNT_W  = 16;
  localparam int PC_W   = 7;
  localparam int RED_W  = PART_W + NIB_W;

  // register reset values
  localparam logic [PC_W-1:0]  PC_RESET    = 7'd1;
  localparam logic [CNT_W-1:0] BATCH_RESET = 16'd1000;

  // input kinds
  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // register indexes (word address bit 2)
  localparam logic REG_PART_COUNT     = 1'b0;
  localparam logic REG_BATCH_INTERVAL = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] key_top;
    logic [63:0] key_middle;
    logic [31:0] key_bottom;
  } in_word_t;

  typedef struct packed {
    logic [PART_W-1:0] partition;
    logic              flush;
    logic [CNT_W-1:0]  batch_count;
    logic              last;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_KRD,
    ST_KUPD,
    ST_FRD,
    ST_FCHK,
    ST_FEND
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic mod_step;
    logic key_rd;
    logic key_upd;
    logic scan_rd;
    logic scan_chk;
    logic scan_end;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic scan_done;
  } dp_stat_t;

endpackage

// File: rtl/core/dmpb_regs.sv
// ----------------------------------------------------------------------------
// dmpb_regs
// APB-style configuration registers: partition count and batch interval.
// ----------------------------------------------------------------------------
module dmpb_regs
  import dmpb_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [PC_W-1:0]  partition_count,
  output logic [CNT_W-1:0] batch_interval
);

  logic [PC_W-1:0]  pc_r;
  logic [CNT_W-1:0] bi_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write, word selected by address bit 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_RESET;
      bi_r <= BATCH_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PART_COUNT:     pc_r <= pwdata[PC_W-1:0];
        REG_BATCH_INTERVAL: bi_r <= pwdata[CNT_W-1:0];
        default:            ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (paddr[2])
      REG_PART_COUNT:     prdata = 32'(pc_r);
      REG_BATCH_INTERVAL: prdata = 32'(bi_r);
      default:            prdata = '0;
    endcase
  end

  assign partition_count = pc_r;
  assign batch_interval  = bi_r;

endmodule

// File: rtl/core/dmpb_ctrl.sv
// ----------------------------------------------------------------------------
// dmpb_ctrl
// Sequencer: nibble reduction, counter update, and the finish scan.
// ----------------------------------------------------------------------------
module dmpb_ctrl
  import dmpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     kind,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     busy
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = (kind == KIND_FINISH) ? ST_FRD : ST_MOD;
        end
      end
      ST_MOD: begin
        if (stat.mod_done) begin
          state_nxt = ST_KRD;
        end
      end
      ST_KRD:  state_nxt = ST_KUPD;
      ST_KUPD: state_nxt = ST_IDLE;
      ST_FRD:  state_nxt = ST_FCHK;
      ST_FCHK: state_nxt = stat.scan_done ? ST_FEND : ST_FRD;
      ST_FEND: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_MOD:  cmd.mod_step = 1'b1;
      ST_KRD:  cmd.key_rd   = 1'b1;
      ST_KUPD: cmd.key_upd  = 1'b1;
      ST_FRD:  cmd.scan_rd  = 1'b1;
      ST_FCHK: cmd.scan_chk = 1'b1;
      ST_FEND: cmd.scan_end = 1'b1;
      default: ;
    endcase
  end

endmodule

// File: rtl/core/dmpb_dp.sv
// ----------------------------------------------------------------------------
// dmpb_dp
// Datapath: key shifter, nibble-serial remainder, counter memory with
// valid bits, finish scan with one-result lookahead, and the output word.
// ----------------------------------------------------------------------------
module dmpb_dp
  import dmpb_pkg::*;
#(
  parameter int MAX_PARTITIONS = 64
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  in_word_t         in_word,
  input  logic [PC_W-1:0]  partition_count,
  input  logic [CNT_W-1:0] batch_interval,
  output dp_stat_t         stat,
  output logic             out_valid,
  output out_word_t        out_word
);

  localparam int PIDX_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam logic [PC_W-1:0]     PC_MAX   = PC_W'(MAX_PARTITIONS);
  localparam logic [PIDX_W-1:0]   SCAN_END = PIDX_W'(MAX_PARTITIONS - 1);
  localparam logic [NIBCNT_W-1:0] NIB_END  = NIBCNT_W'(KEY_NIBBLES - 1);

  // key and remainder
  logic [KEY_W-1:0]    key_r;
  logic [NIBCNT_W-1:0] nib_cnt_r;
  logic [PART_W-1:0]   rem_r;
  logic [PC_W-1:0]     div;
  logic [RED_W-1:0]    dv, x0, x1, x2, x3, x4;

  // counter store
  logic [CNT_W-1:0]          mem_r [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] valid_r;
  logic [CNT_W-1:0]          rd_data_r;
  logic [PIDX_W-1:0]         rem_idx;
  logic [PIDX_W-1:0]         rd_addr;
  logic [CNT_W-1:0]          cnt_old, cnt_inc;
  logic                      key_flush;

  // finish scan
  logic [PIDX_W-1:0] scan_r;
  logic              pend_valid_r;
  logic [PART_W-1:0] pend_part_r;
  logic [CNT_W-1:0]  pend_cnt_r;
  logic              scan_hit;

  // output
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;

  // effective divisor: zero acts as one, saturate at the store depth
  always_comb begin
    if (partition_count == '0) begin
      div = PC_W'(1);
    end else if (partition_count > PC_MAX) begin
      div = PC_MAX;
    end else begin
      div = partition_count;
    end
  end

  // one nibble step: (rem*16 + nib) < 16*div, four conditional subtracts
  assign dv = RED_W'(div);
  assign x0 = {rem_r, key_r[KEY_W-1 -: NIB_W]};
  assign x1 = (x0 >= (dv << 3)) ? x0 - (dv << 3) : x0;
  assign x2 = (x1 >= (dv << 2)) ? x1 - (dv << 2) : x1;
  assign x3 = (x2 >= (dv << 1)) ? x2 - (dv << 1) : x2;
  assign x4 = (x3 >= dv)        ? x3 - dv        : x3;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r     <= {in_word.key_top, in_word.key_middle, in_word.key_bottom};
      rem_r     <= '0;
      nib_cnt_r <= '0;
    end else if (cmd.mod_step) begin
      key_r     <= key_r << NIB_W;
      rem_r     <= x4[PART_W-1:0];
      nib_cnt_r <= nib_cnt_r + NIBCNT_W'(1);
    end
  end

  assign stat.mod_done  = (nib_cnt_r == NIB_END);
  assign stat.scan_done = (scan_r == SCAN_END);

  // single read port, registered data
  assign rem_idx = rem_r[PIDX_W-1:0];
  assign rd_addr = cmd.scan_rd ? scan_r : rem_idx;

  always_ff @(posedge clk) begin
    if (cmd.key_rd || cmd.scan_rd) begin
      rd_data_r <= mem_r[rd_addr];
    end
    if (cmd.key_upd) begin
      mem_r[rem_idx] <= cnt_inc;
    end
  end

  // key update: invalid entry reads as zero
  assign cnt_old   = valid_r[rem_idx] ? rd_data_r : '0;
  assign cnt_inc   = cnt_old + CNT_W'(1);
  assign key_flush = (cnt_inc >= batch_interval);
  assign scan_hit  = valid_r[scan_r];

  // valid bit set means a nonzero count is stored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.key_upd) begin
      valid_r[rem_idx] <= ~key_flush & (cnt_inc != '0);
    end else if (cmd.scan_chk) begin
      valid_r[scan_r] <= 1'b0;
    end
  end

  // scan index and pending flush (held back so last can be marked)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.load) begin
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
    end else if (cmd.scan_chk) begin
      if (!stat.scan_done) begin
        scan_r <= scan_r + PIDX_W'(1);
      end
      if (scan_hit) begin
        pend_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_chk && scan_hit) begin
      pend_part_r <= PART_W'(scan_r);
      pend_cnt_r  <= rd_data_r;
    end
  end

  // result word
  always_comb begin
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    if (cmd.key_upd) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.partition   = rem_r;
      out_word_nxt.flush       = key_flush;
      out_word_nxt.batch_count = cnt_inc;
      out_word_nxt.last        = 1'b1;
    end else if (cmd.scan_chk) begin
      out_valid_nxt            = scan_hit & pend_valid_r;
      out_word_nxt.partition   = pend_part_r;
      out_word_nxt.flush       = 1'b1;
      out_word_nxt.batch_count = pend_cnt_r;
      out_word_nxt.last        = 1'b0;
    end else if (cmd.scan_end) begin
      out_valid_nxt            = 1'b1;
      out_word_nxt.partition   = pend_valid_r ? pend_part_r : '0;
      out_word_nxt.flush       = pend_valid_r;
      out_word_nxt.batch_count = pend_valid_r ? pend_cnt_r : '0;
      out_word_nxt.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/core/digest_mod_partitioner_batcher.sv
// ----------------------------------------------------------------------------
// digest_mod_partitioner_batcher
// Maps 160-bit digest keys to partitions and keeps per-partition batch counts.
// ----------------------------------------------------------------------------
// A key word is taken when start is high and busy low. Its partition is
// the key modulo the partition count, reduced one nibble per cycle, then
// the partition counter is read and updated through a single-port counter
// memory in a read step and an update step; the one result appears in the
// first cycle with busy low, when the next word may already be started.
// A finish word scans all MAX_PARTITIONS counters, each in a read step and
// then a check step, followed by a closing step. Flush results come from
// the check steps, except that the final one comes from the closing step
// and may directly follow the one before it. Results are strobed by out_valid
// for one cycle and cannot be stalled. Counters are valid-bit tracked, so no
// clearing pass follows reset.
module digest_mod_partitioner_batcher
  import dmpb_pkg::*;
#(
  parameter int MAX_PARTITIONS = 64
)
(
  input  logic      clk,
  input  logic      rst_n,
  // input channel
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  // result channel
  output logic      out_valid,
  output out_word_t out_word,
  // configuration
  input  logic      psel,
  input  logic      penable,
  input  logic      pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic      pready
);

  logic [PC_W-1:0]  partition_count;
  logic [CNT_W-1:0] batch_interval;
  dp_cmd_t          cmd;
  dp_stat_t         stat;

  dmpb_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .partition_count (partition_count),
    .batch_interval  (batch_interval)
  );

  dmpb_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .kind  (in_word.kind),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  dmpb_dp #(
    .MAX_PARTITIONS (MAX_PARTITIONS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_word         (in_word),
    .partition_count (partition_count),
    .batch_interval  (batch_interval),
    .stat            (stat),
    .out_valid       (out_valid),
    .out_word        (out_word)
  );

endmodule

// File: rtl/core/dmpb_checker.sv
// ----------------------------------------------------------------------------
// dmpb_checker
// Port-level checks for the partitioner, bound to the top level.
// ----------------------------------------------------------------------------
module dmpb_checker
  import dmpb_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_word_t out_word
);

  // an accepted word keeps the block busy in the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted word did not raise busy");

  // more results pending: block still busy
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.last |-> busy)
    else $error("non-final result while idle");

  // final result: block already free
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |-> !busy)
    else $error("final result while still busy");

  // a non-flush result always ends its word
  a_noflush_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_word.flush |-> out_word.last)
    else $error("non-flush result not marked last");

  // finish flushes only report nonzero counts
  a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.flush && !out_word.last |-> out_word.batch_count != '0)
    else $error("scan flushed an empty partition");

endmodule

bind digest_mod_partitioner_batcher dmpb_checker u_dmpb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_word  (out_word)
);

// File: tb/sv/tb_digest_mod_partitioner_batcher.sv
// ----------------------------------------------------------------------------
// tb_digest_mod_partitioner_batcher
// Self-checking bench for the digest modulo partitioner / batcher. Key and
// finish words go in through the start/busy handshake. A behavioral model of
// the partition reduction and the per-partition counters predicts every
// result word, and each strobed result is checked field by field against the
// oldest prediction. Register writes go over the APB port, only while idle.
// ----------------------------------------------------------------------------
module tb_digest_mod_partitioner_batcher;
  import dmpb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_PARTS       = 64;
  localparam int STALL_LIMIT     = 3000;
  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 49;

  logic        clk;
  logic        rst_n;
  logic        cmd_start;
  logic        busy;
  in_word_t    cmd_word;
  logic        out_valid;
  out_word_t   out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // model state: register copies and per-partition record counts
  logic [PC_W-1:0]  part_count_reg;
  logic [CNT_W-1:0] interval_reg;
  logic [CNT_W-1:0] record_counts [NUM_PARTS];

  out_word_t expected_results[$];
  in_word_t  recent_keys[$];
  int        fail_count;
  int        idle_cycles;
  bit        no_idle;

  digest_mod_partitioner_batcher #(.MAX_PARTITIONS(NUM_PARTS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd_start),
    .busy     (busy),
    .in_word  (cmd_word),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------

  // key as a 40-nibble big-endian number, reduced one nibble at a time
  function automatic logic [PART_W-1:0] key_partition(in_word_t w);
    logic [KEY_W-1:0] digest;
    int unsigned      divisor;
    int unsigned      rem;
    digest  = {w.key_top, w.key_middle, w.key_bottom};
    divisor = part_count_reg;
    if (divisor == 0) divisor = 1;
    if (divisor > NUM_PARTS) divisor = NUM_PARTS;
    rem = 0;
    for (int i = KEY_NIBBLES - 1; i >= 0; i--)
      rem = (rem * 16 + digest[i*NIB_W +: NIB_W]) % divisor;
    return rem[PART_W-1:0];
  endfunction

  // queue the result words an accepted word will produce
  task automatic predict_results(in_word_t w);
    out_word_t        res;
    logic [PART_W-1:0] part;
    logic [CNT_W-1:0] cnt;
    int               first_flush;
    if (w.kind == KIND_KEY) begin
      part = key_partition(w);
      cnt  = record_counts[part] + 16'd1;
      res.partition   = part;
      res.batch_count = cnt;
      res.last        = 1'b1;
      // interval of zero always flushes
      if (cnt >= interval_reg) begin
        res.flush = 1'b1;
        record_counts[part] = '0;
      end else begin
        res.flush = 1'b0;
        record_counts[part] = cnt;
      end
      expected_results = {expected_results, res};
    end else begin
      // finish scans every counter, including ones above the divisor
      first_flush = expected_results.size();
      for (int j = 0; j < NUM_PARTS; j++) begin
        if (record_counts[j] != 0) begin
          res.partition   = j[PART_W-1:0];
          res.flush       = 1'b1;
          res.batch_count = record_counts[j];
          res.last        = 1'b0;
          expected_results = {expected_results, res};
          record_counts[j] = '0;
        end
      end
      if (expected_results.size() == first_flush) begin
        res = '0;
        res.last = 1'b1;
        expected_results = {expected_results, res};
      end else begin
        expected_results[expected_results.size()-1].last = 1'b1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_word_t exp_res;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word part=%0d flush=%0b count=%0d last=%0b",
                 $time, out_word.partition, out_word.flush, out_word.batch_count,
                 out_word.last);
        fail_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_word.partition !== exp_res.partition) begin
          $display("%0t: partition mismatch: expected %0d, actual %0d",
                   $time, exp_res.partition, out_word.partition);
          fail_count++;
        end
        if (out_word.flush !== exp_res.flush) begin
          $display("%0t: flush mismatch (partition %0d): expected %0b, actual %0b",
                   $time, exp_res.partition, exp_res.flush, out_word.flush);
          fail_count++;
        end
        if (out_word.batch_count !== exp_res.batch_count) begin
          $display("%0t: batch_count mismatch (partition %0d): expected %0d, actual %0d",
                   $time, exp_res.partition, exp_res.batch_count, out_word.batch_count);
          fail_count++;
        end
        if (out_word.last !== exp_res.last) begin
          $display("%0t: last mismatch (partition %0d): expected %0b, actual %0b",
                   $time, exp_res.partition, exp_res.last, out_word.last);
          fail_count++;
        end
      end
    end
  end

  // watchdog: ends the run after a long stretch with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (cmd_start && !busy) || out_valid || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 15);
    return $urandom_range(16, 60);
  endfunction

  // APB write: setup then access, register updates when pready is seen
  task automatic cfg_write(logic idx, logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PART_COUNT:     part_count_reg = value[PC_W-1:0];
      REG_BATCH_INTERVAL: interval_reg   = value[CNT_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // hold start until the word is taken, then idle for a random gap
  task automatic send_word(in_word_t w);
    int gap;
    cmd_start <= 1'b1;
    cmd_word  <= w;
    do @(posedge clk); while (busy);
    predict_results(w);
    if (w.kind == KIND_KEY) begin
      recent_keys = {recent_keys, w};
      if (recent_keys.size() > 8) void'(recent_keys.pop_front());
    end
    gap = pick_gap();
    if (gap > 0) begin
      cmd_start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait for all predicted words and for the block to go idle
  task automatic wait_quiet();
    cmd_start <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_word_t make_key(logic [63:0] top, logic [63:0] mid,
                                        logic [31:0] bot);
    in_word_t w;
    w.kind       = KIND_KEY;
    w.key_top    = top;
    w.key_middle = mid;
    w.key_bottom = bot;
    return w;
  endfunction

  function automatic in_word_t make_finish();
    in_word_t w;
    w.kind       = KIND_FINISH;
    w.key_top    = {$urandom, $urandom};
    w.key_middle = {$urandom, $urandom};
    w.key_bottom = $urandom;
    return w;
  endfunction

  // random traffic: finish words, reused keys to build up counts, sparse and full keys
  function automatic in_word_t pick_traffic_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return make_finish();
    if (r < 45 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    if (r < 60)
      return make_key('0, ($urandom_range(0, 1) ? '1 : '0), $urandom_range(0, 255));
    return make_key({$urandom, $urandom}, {$urandom, $urandom}, $urandom);
  endfunction

  function automatic logic [31:0] pick_part_count();
    case ($urandom_range(0, 7))
      0:       return 32'd1;
      1:       return 32'd64;
      2:       return 32'd0;
      3:       return $urandom_range(65, 127);
      4:       return $urandom_range(2, 8);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [31:0] pick_interval();
    case ($urandom_range(0, 7))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return 32'd65535;
      3:       return 32'd1000;
      4, 5:    return $urandom_range(2, 6);
      default: return $urandom_range(1, 30);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // reset settings: one partition, interval 1000; finish with and without counts
  task automatic test_reset_defaults();
    send_word(make_key('0, '0, '0));
    send_word(make_key('1, '1, '1));
    send_word(make_finish());
    send_word(make_finish());
    wait_quiet();
  endtask

  // full, zero and oversized partition counts
  task automatic test_partition_count_limits();
    cfg_write(REG_PART_COUNT, 32'd64);
    send_word(make_key('1, '1, '1));
    send_word(make_key('0, '0, 32'd63));
    send_word(make_key(64'h8000_0000_0000_0000, '0, '0));
    wait_quiet();
    // zero acts as one partition
    cfg_write(REG_PART_COUNT, 32'd0);
    send_word(make_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 32'hDEAD_BEEF));
    wait_quiet();
    // above the maximum saturates to 64
    cfg_write(REG_PART_COUNT, 32'd127);
    send_word(make_key('0, '0, 32'd127));
    send_word(make_key('1, '1, '1));
    wait_quiet();
  endtask

  // interval of zero, then an interval lowered below a partition's count
  task automatic test_batch_interval();
    cfg_write(REG_PART_COUNT, 32'd1);
    cfg_write(REG_BATCH_INTERVAL, 32'd0);
    send_word(make_key('0, '0, 32'd5));
    send_word(make_key('0, '0, 32'd5));
    wait_quiet();
    cfg_write(REG_BATCH_INTERVAL, 32'd10);
    repeat (3) send_word(make_key('0, '0, 32'd9));
    wait_quiet();
    cfg_write(REG_BATCH_INTERVAL, 32'd2);
    send_word(make_key('0, '0, 32'd9));
    wait_quiet();
  endtask

  // counts above a reduced partition count are still flushed by finish
  task automatic test_shrunk_partitions();
    cfg_write(REG_BATCH_INTERVAL, 32'd65535);
    cfg_write(REG_PART_COUNT, 32'd64);
    send_word(make_key('0, '0, 32'd63));
    send_word(make_key('0, '0, 32'd40));
    wait_quiet();
    cfg_write(REG_PART_COUNT, 32'd4);
    send_word(make_key('0, '0, 32'd2));
    send_word(make_finish());
    wait_quiet();
  endtask

  // random phases, each with freshly picked or carried-over settings and its own idling mode
  task automatic test_random_traffic();
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 0 || $urandom_range(0, 3) != 0)
        cfg_write(REG_PART_COUNT, pick_part_count());
      if (phase == 0 || $urandom_range(0, 3) != 0)
        cfg_write(REG_BATCH_INTERVAL, pick_interval());
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        send_word(pick_traffic_word());
      no_idle = 1'b0;
      wait_quiet();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    fail_count     = 0;
    no_idle        = 1'b0;
    part_count_reg = PC_RESET;
    interval_reg   = BATCH_RESET;
    for (int i = 0; i < NUM_PARTS; i++) record_counts[i] = '0;
    rst_n     <= 1'b0;
    cmd_start <= 1'b0;
    cmd_word  <= '0;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_partition_count_limits();
    test_batch_interval();
    test_shrunk_partitions();
    test_random_traffic();

    wait_quiet();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0t: %0d mismatches, %0d result words never seen",
               $time, fail_count, expected_results.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/dmpb_pkg.sv
rtl/core/dmpb_regs.sv
rtl/core/dmpb_ctrl.sv
rtl/core/dmpb_dp.sv
rtl/core/digest_mod_partitioner_batcher.sv
rtl/core/dmpb_checker.sv
tb/sv/tb_digest_mod_partitioner_batcher.sv
